// ===== rtl/core/didq_pkg.sv =====
package didq_pkg;

  localparam int COUNT_W = 5;

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_BACK   = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_INSERT     = 3'd4;
  localparam logic [2:0] ACT_SORT       = 3'd5;
  localparam logic [2:0] ACT_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] CELL_HOLD       = 3'd0;
  localparam logic [2:0] CELL_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CELL_PUSH_FRONT = 3'd2;
  localparam logic [2:0] CELL_POP_FRONT  = 3'd3;
  localparam logic [2:0] CELL_INSERT     = 3'd4;
  localparam logic [2:0] CELL_SORT       = 3'd5;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]   popped;
    logic [COUNT_W-1:0]   count;
    logic [1:0]           status;
  } out_word_t;

  typedef struct packed {
    logic [2:0] op;
    logic       odd;
  } cell_ctl_t;

  typedef struct packed {
    logic occ;
    logic occ_left;
    logic occ_right;
    logic tail;
    logic ahead;
    logic at_pos;
  } cell_pos_t;

endpackage

// ===== rtl/core/didq_cell.sv =====
module didq_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter bit ODD         = 1'b0
) (
  input  logic                          clk,
  input  didq_pkg::cell_ctl_t           ctl,
  input  didq_pkg::cell_pos_t           pos,
  input  logic signed [VALUE_WIDTH-1:0] in_val,
  input  logic signed [VALUE_WIDTH-1:0] left,
  input  logic signed [VALUE_WIDTH-1:0] right,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic                          ge
);
  import didq_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_next;

  assign ge = !(pos.occ && (val < in_val));

  always_comb begin
    val_next = val;
    unique case (ctl.op)
      CELL_PUSH_BACK: begin
        if (pos.tail) val_next = in_val;
      end
      CELL_PUSH_FRONT: val_next = left;
      CELL_POP_FRONT:  val_next = right;
      CELL_INSERT: begin
        if (pos.at_pos) val_next = in_val;
        else if (!pos.ahead) val_next = left;
      end
      CELL_SORT: begin
        // left of a pair keeps the smaller, right of a pair the larger
        if (ODD == ctl.odd) begin
          if (pos.occ_right && (right < val)) val_next = right;
        end else begin
          if (pos.occ_left && pos.occ && (val < left)) val_next = left;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/core/integer_deque_with_sorted_insert.sv =====
// channel | signals                       | word
// input   | in_valid, in_ready, in_data   | action, value
// output  | out_valid, out_ready, out_data| popped, count, status
//
// push, pop, sorted insert, clear: each word is applied to the cell row as it is accepted
// sort: odd-even transposition passes with two or more entries, no passes otherwise
// input stalls while a sort runs or while a result waits untaken
// rst clears fill, sort state and out_valid; cell values and out_data stay
module integer_deque_with_sorted_insert #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  didq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output didq_pkg::out_word_t out_data
);
  import didq_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] phase;
  logic [FILL_W-1:0] phase_next;
  logic              sorting;
  logic              sorting_next;
  logic              load_out;
  logic              acc;
  logic              full;
  logic              empty;
  logic [1:0]        status;
  logic [2:0]        op;
  logic [FILL_W-1:0] tail_pos;

  logic signed [VALUE_WIDTH-1:0] in_val;
  logic signed [VALUE_WIDTH-1:0] pop_val;
  logic signed [31:0]            pop_word;
  logic signed [VALUE_WIDTH-1:0] vals [DEPTH];
  logic [DEPTH-1:0]              ge_vec;
  logic [DEPTH-1:0]              first_ge;
  logic [DEPTH-1:0]              ahead_vec;
  cell_ctl_t                     ctl;

  generate
    if (VALUE_WIDTH <= 32) begin : g_in_narrow
      assign in_val = in_data.value[VALUE_WIDTH-1:0];
    end else begin : g_in_wide
      assign in_val = {{(VALUE_WIDTH-32){in_data.value[31]}}, in_data.value};
    end
    if (VALUE_WIDTH >= 32) begin : g_out_narrow
      assign pop_word = pop_val[31:0];
    end else begin : g_out_wide
      assign pop_word = {{(32-VALUE_WIDTH){pop_val[VALUE_WIDTH-1]}}, pop_val};
    end
  endgenerate

  assign in_ready  = !sorting && (!out_valid || out_ready);
  assign acc       = in_valid && in_ready;
  assign full      = (fill == FILL_W'(DEPTH));
  assign empty     = (fill == '0);
  assign tail_pos  = fill - 1'b1;
  assign first_ge  = ge_vec & (~ge_vec + 1'b1);
  assign ahead_vec = first_ge - 1'b1;
  assign ctl.op    = op;
  assign ctl.odd   = phase[0];

  always_comb begin
    op           = CELL_HOLD;
    fill_next    = fill;
    status       = ST_OK;
    pop_val      = '0;
    load_out     = 1'b0;
    sorting_next = sorting;
    phase_next   = phase;
    if (sorting) begin
      op         = CELL_SORT;
      phase_next = phase + 1'b1;
      if (phase == tail_pos) begin
        sorting_next = 1'b0;
        load_out     = 1'b1;
      end
    end else if (acc) begin
      load_out = 1'b1;
      unique case (in_data.action)
        ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            fill_next = fill + 1'b1;
            unique case (in_data.action)
              ACT_PUSH_BACK:  op = CELL_PUSH_BACK;
              ACT_PUSH_FRONT: op = CELL_PUSH_FRONT;
              default:        op = CELL_INSERT;
            endcase
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            fill_next = tail_pos;
            pop_val   = vals[tail_pos[IDX_W-1:0]];
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            fill_next = tail_pos;
            pop_val   = vals[0];
            op        = CELL_POP_FRONT;
          end
        end
        ACT_SORT: begin
          if (fill > FILL_W'(1)) begin
            load_out     = 1'b0;
            sorting_next = 1'b1;
            phase_next   = '0;
          end
        end
        ACT_CLEAR: fill_next = '0;
        default:   fill_next = fill;
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [FILL_W-1:0] IDX = FILL_W'(i);
      cell_pos_t                     pos;
      logic signed [VALUE_WIDTH-1:0] left;
      logic signed [VALUE_WIDTH-1:0] right;

      assign pos.occ       = IDX < fill;
      assign pos.occ_left  = (i > 0) && (IDX <= fill);
      assign pos.occ_right = (i < DEPTH - 1) && ((IDX + 1'b1) < fill);
      assign pos.tail      = IDX == fill;
      assign pos.ahead     = ahead_vec[i];
      assign pos.at_pos    = first_ge[i];

      if (i == 0) begin : g_first
        assign left = in_val;
      end else begin : g_left
        assign left = vals[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right = vals[i];
      end else begin : g_right
        assign right = vals[i+1];
      end

      didq_cell #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .ODD        (i % 2 == 1)
      ) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .pos   (pos),
        .in_val(in_val),
        .left  (left),
        .right (right),
        .val   (vals[i]),
        .ge    (ge_vec[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      sorting   <= 1'b0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      fill    <= fill_next;
      sorting <= sorting_next;
      phase   <= phase_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.popped <= pop_word;
      out_data.count  <= COUNT_W'(fill_next);
      out_data.status <= status;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill beyond depth");

  a_sort_stall: assert property (@(posedge clk) disable iff (rst)
    sorting |-> !in_ready)
    else $error("input taken during sort");

  a_sort_fill: assert property (@(posedge clk) disable iff (rst)
    sorting |=> fill == $past(fill))
    else $error("fill moved during sort");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_data.action != ACT_SORT)) |=> out_valid)
    else $error("no result for accepted word");
`endif

endmodule
